// ===== hdl/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants
// Widths, symbol codes, register indexes and reset values used by the
// signed integer to radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int VALUE_W     = 32;
    localparam int SYMBOL_W    = 8;
    localparam int ALPHA_W     = 64;
    localparam int LEN_W       = 5;
    localparam int DIGIT_W     = 4;
    localparam int NUM_SYMBOLS = 16;
    localparam int MAX_BASE    = 16;
    localparam int CFG_INDEX_W = 2;

    // Up to 32 digits for a 32-bit magnitude in base 2
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    // Must be a power of two: queue pointers wrap by truncation
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;

    localparam logic [LEN_W-1:0]   BASE_LENGTH_RESET   = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] ALPHABET_HIGH_RESET = 64'h0000_0000_0000_3938;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_LENGTH   = 2'd0,
        REG_ALPHABET_LOW  = 2'd1,
        REG_ALPHABET_HIGH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]   base_length;
        logic [ALPHA_W-1:0] alphabet_low;
        logic [ALPHA_W-1:0] alphabet_high;
    } cfg_view_t;

    typedef struct packed {
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t data;
    } queue_push_t;

    typedef struct packed {
        logic  full;
        logic  empty;
        item_t head;
    } queue_status_t;

endpackage

// ===== hdl/sirt_if.sv =====
// ----------------------------------------------------------------------------
// sirt_if: channel interfaces
// Valid/ready channels for input values, output characters and
// configuration writes.
// ----------------------------------------------------------------------------
interface sirt_value_if;
    import sirt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sirt_symbol_if;
    import sirt_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface sirt_cfg_if;
    import sirt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [ALPHA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sirt_front.sv =====
// ----------------------------------------------------------------------------
// sirt_front: configuration registers and input classification
// Holds the base registers, checks the alphabet, splits each value into
// sign and magnitude and pushes it to the queue.
// ----------------------------------------------------------------------------
module sirt_front (
    input  logic                   clk,
    input  logic                   rst_n,
    sirt_cfg_if.sink               cfg,
    sirt_value_if.sink             item,
    input  sirt_pkg::queue_status_t qstat,
    output sirt_pkg::queue_push_t   qpush,
    output sirt_pkg::cfg_view_t     view
);
    import sirt_pkg::*;

    logic [LEN_W-1:0]   base_length_reg;
    logic [ALPHA_W-1:0] alphabet_low_reg;
    logic [ALPHA_W-1:0] alphabet_high_reg;
    logic [VALUE_W-1:0] raw;
    logic               negative;
    logic               base_valid;

    // Length within range, no sign symbol, no repeated symbol among those used
    function automatic logic base_ok(cfg_view_t v);
        logic                         ok;
        logic [2*ALPHA_W-1:0]         all;
        logic [SYMBOL_W-1:0]          s [NUM_SYMBOLS];
        ok  = (v.base_length > LEN_W'(1)) && (v.base_length <= LEN_W'(MAX_BASE));
        all = {v.alphabet_high, v.alphabet_low};
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            s[i] = all[i*SYMBOL_W +: SYMBOL_W];
        end
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (LEN_W'(i) < v.base_length)
            begin
                if ((s[i] == SYM_PLUS) || (s[i] == SYM_MINUS))
                begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < NUM_SYMBOLS; j++)
                begin
                    if ((LEN_W'(j) < v.base_length) && (s[j] == s[i]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg   <= BASE_LENGTH_RESET;
            alphabet_low_reg  <= ALPHABET_LOW_RESET;
            alphabet_high_reg <= ALPHABET_HIGH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_BASE_LENGTH:   base_length_reg   <= cfg.data[LEN_W-1:0];
                REG_ALPHABET_LOW:  alphabet_low_reg  <= cfg.data;
                REG_ALPHABET_HIGH: alphabet_high_reg <= cfg.data;
                default:           ; // drop writes beyond the register list
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    assign view.base_length   = base_length_reg;
    assign view.alphabet_low  = alphabet_low_reg;
    assign view.alphabet_high = alphabet_high_reg;

    assign base_valid = base_ok(view);
    assign raw        = unsigned'(item.value);
    assign negative   = raw[VALUE_W-1];

    assign item.ready               = !qstat.full;
    // An item under an invalid base is taken and dropped
    assign qpush.push               = item.valid && !qstat.full && base_valid;
    assign qpush.data.negative      = negative;
    assign qpush.data.magnitude     = negative ? (VALUE_W'(0) - raw) : raw;

endmodule

// ===== hdl/sirt_queue.sv =====
// ----------------------------------------------------------------------------
// sirt_queue: item queue between front and back
// Small register FIFO holding sign and magnitude of accepted values.
// ----------------------------------------------------------------------------
module sirt_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sirt_pkg::queue_push_t   qpush,
    input  logic                    pop,
    output sirt_pkg::queue_status_t qstat
);
    import sirt_pkg::*;

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (qpush.push)
        begin
            entries_reg[wr_ptr_reg] <= qpush.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (qpush.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({qpush.push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: ;
            endcase
        end
    end

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.head  = entries_reg[rd_ptr_reg];

endmodule

// ===== hdl/sirt_back.sv =====
// ----------------------------------------------------------------------------
// sirt_back: digit generation and character output
// Divides the magnitude by the base a byte per cycle, stacks the digits,
// then emits the digits most significant first, after '-' if negative.
// ----------------------------------------------------------------------------
module sirt_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sirt_pkg::cfg_view_t     view,
    input  sirt_pkg::queue_status_t qstat,
    output logic                    pop,
    sirt_symbol_if.source           text
);
    import sirt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } state_t;

    localparam int BYTES = VALUE_W / 8;
    localparam int STEP_W = $clog2(BYTES);

    state_t                 state_reg,      state_next;
    logic [VALUE_W-1:0]     mag_reg,        mag_next;
    logic [DIGIT_W-1:0]     rem_reg,        rem_next;
    logic [STEP_W-1:0]      step_reg,       step_next;
    logic [DIGIT_CNT_W-1:0] nd_reg,         nd_next;
    logic [DIGIT_IDX_W-1:0] ptr_reg,        ptr_next;
    logic                   neg_reg,        neg_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [SYMBOL_W-1:0]    out_symbol_reg, out_symbol_next;
    logic                   out_last_reg,   out_last_next;
    logic [DIGIT_W-1:0]     digits_reg [MAX_DIGITS];

    logic [DIGIT_W:0]       div_r;
    logic [7:0]             div_q;
    logic [VALUE_W-1:0]     div_mag;
    logic                   load;
    logic                   push_digit;
    logic [2*ALPHA_W-1:0]   alphabet;
    logic [SYMBOL_W-1:0]    digit_symbol;

    // One byte of restoring long division by the base
    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_q = '0;
        for (int k = 7; k >= 0; k--)
        begin
            div_r = {div_r[DIGIT_W-1:0], mag_reg[VALUE_W-8+k]};
            if (div_r >= view.base_length)
            begin
                div_r    = div_r - view.base_length;
                div_q[k] = 1'b1;
            end
        end
        div_mag = {mag_reg[VALUE_W-9:0], div_q};
    end

    assign alphabet     = {view.alphabet_high, view.alphabet_low};
    assign digit_symbol = alphabet[{digits_reg[ptr_reg], 3'b000} +: SYMBOL_W];
    assign load         = !out_valid_reg || text.ready;
    assign pop          = (state_reg == S_IDLE) && !qstat.empty;
    assign push_digit   = (state_reg == S_DIV) && (step_reg == STEP_W'(BYTES - 1));

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        nd_next         = nd_reg;
        ptr_next        = ptr_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !text.ready;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    mag_next   = qstat.head.magnitude;
                    neg_next   = qstat.head.negative;
                    rem_next   = '0;
                    step_next  = '0;
                    nd_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                mag_next  = div_mag;
                rem_next  = div_r[DIGIT_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (push_digit)
                begin
                    rem_next = '0;
                    nd_next  = nd_reg + DIGIT_CNT_W'(1);
                    if ((div_mag == '0) || (nd_reg == DIGIT_CNT_W'(MAX_DIGITS - 1)))
                    begin
                        ptr_next   = nd_reg[DIGIT_IDX_W-1:0];
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_symbol_next = SYM_MINUS;
                    out_last_next   = 1'b0;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_symbol_next = digit_symbol;
                    out_last_next   = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - DIGIT_IDX_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_digit)
        begin
            digits_reg[nd_reg[DIGIT_IDX_W-1:0]] <= div_r[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            mag_reg        <= '0;
            rem_reg        <= '0;
            step_reg       <= '0;
            nd_reg         <= '0;
            ptr_reg        <= '0;
            neg_reg        <= 1'b0;
            out_symbol_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            mag_reg        <= mag_next;
            rem_reg        <= rem_next;
            step_reg       <= step_next;
            nd_reg         <= nd_next;
            ptr_reg        <= ptr_next;
            neg_reg        <= neg_next;
            out_symbol_reg <= out_symbol_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign text.valid  = out_valid_reg;
    assign text.symbol = out_symbol_reg;
    assign text.last   = out_last_reg;

`ifndef SYNTHESIS
    a_digit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (nd_reg < DIGIT_CNT_W'(MAX_DIGITS)))
        else $error("digit stack overflow");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < view.base_length))
        else $error("partial remainder not below base");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (state_reg == S_EMIT) && (out_symbol_reg == SYM_MINUS))
            |-> !out_last_reg)
        else $error("minus sign marked as last character");

    a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> ((state_reg == S_DIV) && (nd_reg == '0)))
        else $error("dequeued value did not start division");
`endif

endmodule

// ===== hdl/signed_int_to_radix_text.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_text: signed 32-bit integer to text in a set base
// Top level: front (config and classification), item queue, back (digits
// and character output).
// ----------------------------------------------------------------------------
// Usage:
//   item  - input channel, one signed 32-bit value per transaction.
//   text  - output channel, one character per transaction, most significant
//           digit first; a negative value starts with '-'; last marks the
//           final character of each value.
//   cfg   - write channel: index 0 base_length, 1 alphabet_low,
//           2 alphabet_high; always ready. Write only while the block is idle.
//   Under an invalid base a value is accepted and produces no characters.
// Operation, for a value with D digits:
//   the value enters the queue and is dequeued by the back, which divides
//   it by the base in byte-wide remainder steps, one digit at a time, then
//   emits D characters (D+1 if negative) at one per cycle while the
//   receiver is ready. The two-entry queue lets the front accept the next
//   values while the back works.
// Reset: clears the queue and back state, loads base 10 and "0123456789".
// When the receiver stalls, the output register holds the character and
// the back waits; the queue keeps accepting values until it fills.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text (
    input  logic           clk,
    input  logic           rst_n,
    sirt_value_if.sink     item,
    sirt_symbol_if.source  text,
    sirt_cfg_if.sink       cfg
);
    import sirt_pkg::*;

    cfg_view_t     view;
    queue_push_t   qpush;
    queue_status_t qstat;
    logic          pop;

    // Front: hold config, check the alphabet, split sign and magnitude
    sirt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item),
        .qstat (qstat),
        .qpush (qpush),
        .view  (view)
    );

    // Queue: decouple acceptance from digit generation
    sirt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qpush (qpush),
        .pop   (pop),
        .qstat (qstat)
    );

    // Back: divide, stack digits, emit characters through the output register
    sirt_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .view  (view),
        .qstat (qstat),
        .pop   (pop),
        .text  (text)
    );

endmodule
